// ===== rtl/sidt_pkg.sv =====
// ----------------------------------------------------------------------------
// sidt_pkg
// Shared types and constants of the sorted identifier translation table.
// ----------------------------------------------------------------------------
package sidt_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned ClassW   = 8;
  localparam int unsigned IdW      = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD = 2'd0,
    MODE_FWD = 2'd1,
    MODE_REV = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SCMP,
    S_SHIFT,
    S_TAIL,
    S_INSERT,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [ClassW-1:0] cls;
    logic [IdW-1:0]    rid;
    logic [IdW-1:0]    lid;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic          valid;
    logic [IdW-1:0] result_id;
    status_e       status;
  } rsp_t;

endpackage

// ===== rtl/sidt_if.sv =====
// ----------------------------------------------------------------------------
// sidt_req_if / sidt_rsp_if
// Valid/ready channels for translation requests and their responses.
// ----------------------------------------------------------------------------
interface sidt_req_if;
  logic                       valid;
  logic                       ready;
  logic [sidt_pkg::ModeW-1:0]  mode;
  logic [sidt_pkg::ClassW-1:0] entry_class;
  logic [sidt_pkg::IdW-1:0]    remote_id;
  logic [sidt_pkg::IdW-1:0]    local_id;

  modport source (output valid, mode, entry_class, remote_id, local_id, input ready);
  modport sink   (input valid, mode, entry_class, remote_id, local_id, output ready);
endinterface

interface sidt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sidt_pkg::IdW-1:0]     result_id;
  logic [sidt_pkg::StatusW-1:0] status;

  modport source (output valid, result_id, status, input ready);
  modport sink   (input valid, result_id, status, output ready);
endinterface

// ===== rtl/sorted_id_translation_table.sv =====
// ----------------------------------------------------------------------------
// sorted_id_translation_table
// Sorted (class, remote id) to local id map with add, forward and reverse
// lookup, held in one table RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields                                   | handshake
//  --------+-----+------------------------------------------+-------------
//  req     | in  | mode, entry_class, remote_id, local_id   | valid/ready
//  rsp     | out | result_id, status                        | valid/ready
//
//  one request at a time; each binary search probe reads the table RAM in
//  S_SRCH and compares the registered read data in S_SCMP
//  add of a new key then shifts later entries one per cycle, then inserts it
//  reverse lookup scans its class one entry per cycle after the search
//  reset empties the table at once; a waiting response does not block the
//  next request from being taken
//
module sorted_id_translation_table #(
  parameter int unsigned Capacity = sidt_pkg::Capacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sidt_req_if.sink   req,
  sidt_rsp_if.source rsp
);

  localparam int unsigned IdxW = $clog2(Capacity);

  sidt_pkg::rsp_t   eng_rsp;
  sidt_pkg::entry_t ram_wdata, ram_rdata;
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic             rsp_free;

  logic                         ov_q;
  logic [sidt_pkg::IdW-1:0]     result_q;
  logic [sidt_pkg::StatusW-1:0] status_q;

  sidt_engine #(
    .Capacity (Capacity)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .in_mode_i   (req.mode),
    .in_class_i  (req.entry_class),
    .in_rid_i    (req.remote_id),
    .in_lid_i    (req.local_id),
    .rsp_o       (eng_rsp),
    .rsp_free_i  (rsp_free),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  sidt_ram #(
    .Width (sidt_pkg::EntryW),
    .Depth (Capacity)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // response register
  assign rsp_free = !ov_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (eng_rsp.valid) begin
      ov_q <= 1'b1;
    end else if (rsp.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_rsp.valid) begin
      result_q <= eng_rsp.result_id;
      status_q <= eng_rsp.status;
    end
  end

  assign rsp.valid     = ov_q;
  assign rsp.result_id = result_q;
  assign rsp.status    = status_q;

endmodule

// ===== rtl/sidt_ram.sv =====
// ----------------------------------------------------------------------------
// sidt_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sidt_ram #(
  parameter int unsigned Width = sidt_pkg::EntryW,
  parameter int unsigned Depth = sidt_pkg::Capacity
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sidt_engine.sv =====
// ----------------------------------------------------------------------------
// sidt_engine
// Request sequencer: binary search, insert with shift, reverse class scan.
// ----------------------------------------------------------------------------
module sidt_engine #(
  parameter int unsigned Capacity = sidt_pkg::Capacity,
  localparam int unsigned IdxW    = $clog2(Capacity),
  localparam int unsigned CntW    = $clog2(Capacity + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [sidt_pkg::ModeW-1:0]  in_mode_i,
  input  logic [sidt_pkg::ClassW-1:0] in_class_i,
  input  logic [sidt_pkg::IdW-1:0]    in_rid_i,
  input  logic [sidt_pkg::IdW-1:0]    in_lid_i,
  output sidt_pkg::rsp_t              rsp_o,
  input  logic                        rsp_free_i,
  output logic                        ram_we_o,
  output logic [IdxW-1:0]             ram_waddr_o,
  output sidt_pkg::entry_t            ram_wdata_o,
  output logic [IdxW-1:0]             ram_raddr_o,
  input  sidt_pkg::entry_t            ram_rdata_i
);

  sidt_pkg::state_e  state_q, state_d;
  sidt_pkg::mode_e   mode_q, mode_d;
  logic [sidt_pkg::ClassW-1:0] cls_q, cls_d;
  logic [sidt_pkg::IdW-1:0]    rid_q, rid_d;
  logic [sidt_pkg::IdW-1:0]    lid_q, lid_d;
  logic [sidt_pkg::IdW-1:0]    res_q, res_d;
  sidt_pkg::status_e st_q, st_d;
  logic [CntW-1:0]   lo_q, lo_d;
  logic [CntW-1:0]   hi_q, hi_d;
  logic [CntW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   mid_q, mid_d;
  logic [IdxW-1:0]   sh_q, sh_d;
  logic [IdxW-1:0]   wa_q, wa_d;
  logic              wpend_q, wpend_d;
  logic              rv_q, rv_d;

  logic [CntW:0]          mid_sum;
  logic [IdxW-1:0]        mid;
  logic [sidt_pkg::IdW-1:0] key_rid;
  logic cmp_less, cmp_more, cmp_hit;
  logic srch_open, table_full;
  logic scan_hit, scan_end, scan_done;
  sidt_pkg::entry_t rd;

  assign rd        = ram_rdata_i;
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = mid_sum[IdxW:1];
  assign key_rid   = (mode_q == sidt_pkg::MODE_REV) ? '0 : rid_q;
  assign cmp_less  = (cls_q < rd.cls) || ((cls_q == rd.cls) && (key_rid < rd.rid));
  assign cmp_more  = (cls_q > rd.cls) || (key_rid > rd.rid);
  assign cmp_hit   = !cmp_less && !cmp_more;
  assign srch_open = lo_q < hi_q;
  assign table_full = cnt_q == CntW'(Capacity);
  assign scan_hit  = rv_q && (rd.cls == cls_q) && (rd.lid == lid_q);
  assign scan_end  = (rv_q && (rd.cls != cls_q)) || (pos_q >= cnt_q);
  assign scan_done = scan_hit || scan_end;

  assign in_ready_o = state_q == sidt_pkg::S_IDLE;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sidt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (sidt_pkg::mode_e'(in_mode_i))
            sidt_pkg::MODE_ADD,
            sidt_pkg::MODE_FWD,
            sidt_pkg::MODE_REV: state_d = sidt_pkg::S_SRCH;
            default:            state_d = sidt_pkg::S_RESP;
          endcase
        end
      end
      sidt_pkg::S_SRCH: begin
        if (srch_open) begin
          state_d = sidt_pkg::S_SCMP;
        end else begin
          case (mode_q)
            sidt_pkg::MODE_ADD: begin
              if (table_full) begin
                state_d = sidt_pkg::S_RESP;
              end else if (lo_q == cnt_q) begin
                state_d = sidt_pkg::S_INSERT;
              end else begin
                state_d = sidt_pkg::S_SHIFT;
              end
            end
            sidt_pkg::MODE_REV: state_d = sidt_pkg::S_SCAN;
            default:            state_d = sidt_pkg::S_RESP;
          endcase
        end
      end
      sidt_pkg::S_SCMP: begin
        if (!cmp_hit) begin
          state_d = sidt_pkg::S_SRCH;
        end else if (mode_q == sidt_pkg::MODE_REV) begin
          state_d = sidt_pkg::S_SCAN;
        end else begin
          state_d = sidt_pkg::S_RESP;
        end
      end
      sidt_pkg::S_SHIFT: begin
        if (sh_q == pos_q[IdxW-1:0]) begin
          state_d = sidt_pkg::S_TAIL;
        end
      end
      sidt_pkg::S_TAIL:   state_d = sidt_pkg::S_INSERT;
      sidt_pkg::S_INSERT: state_d = sidt_pkg::S_RESP;
      sidt_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = sidt_pkg::S_RESP;
        end
      end
      sidt_pkg::S_RESP: begin
        if (rsp_free_i) begin
          state_d = sidt_pkg::S_IDLE;
        end
      end
      default: state_d = sidt_pkg::S_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    mode_d  = mode_q;
    cls_d   = cls_q;
    rid_d   = rid_q;
    lid_d   = lid_q;
    res_d   = res_q;
    st_d    = st_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    mid_d   = mid_q;
    sh_d    = sh_q;
    wa_d    = wa_q;
    wpend_d = wpend_q;
    rv_d    = rv_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wa_q;
    ram_wdata_o = rd;
    ram_raddr_o = mid;
    rsp_o.valid     = 1'b0;
    rsp_o.result_id = res_q;
    rsp_o.status    = st_q;
    case (state_q)
      sidt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          mode_d = sidt_pkg::mode_e'(in_mode_i);
          cls_d  = in_class_i;
          rid_d  = in_rid_i;
          lid_d  = in_lid_i;
          lo_d   = '0;
          hi_d   = cnt_q;
          case (sidt_pkg::mode_e'(in_mode_i))
            sidt_pkg::MODE_ADD: begin
              res_d = '0;
              st_d  = sidt_pkg::ST_OK;
            end
            sidt_pkg::MODE_FWD: begin
              res_d = in_rid_i;
              st_d  = sidt_pkg::ST_MISS;
            end
            sidt_pkg::MODE_REV: begin
              res_d = in_lid_i;
              st_d  = sidt_pkg::ST_MISS;
            end
            default: begin
              res_d = '0;
              st_d  = sidt_pkg::ST_MISS;
            end
          endcase
        end
      end
      sidt_pkg::S_SRCH: begin
        ram_raddr_o = mid;
        mid_d       = mid;
        if (!srch_open) begin
          pos_d   = lo_q;
          rv_d    = 1'b0;
          wpend_d = 1'b0;
          sh_d    = IdxW'(cnt_q - 1'b1);
          if ((mode_q == sidt_pkg::MODE_ADD) && table_full) begin
            st_d = sidt_pkg::ST_FULL;
          end
        end
      end
      sidt_pkg::S_SCMP: begin
        if (cmp_less) begin
          hi_d = CntW'(mid_q);
        end else if (cmp_more) begin
          lo_d = CntW'(mid_q) + 1'b1;
        end else begin
          pos_d = CntW'(mid_q);
          rv_d  = 1'b0;
          case (mode_q)
            sidt_pkg::MODE_ADD: begin
              if (rd.lid != lid_q) begin
                st_d = sidt_pkg::ST_CONFLICT;
              end
            end
            sidt_pkg::MODE_FWD: begin
              res_d = rd.lid;
              st_d  = sidt_pkg::ST_OK;
            end
            default: ;
          endcase
        end
      end
      sidt_pkg::S_SHIFT: begin
        ram_raddr_o = sh_q;
        ram_we_o    = wpend_q;
        wpend_d     = 1'b1;
        wa_d        = sh_q + 1'b1;
        sh_d        = sh_q - 1'b1;
      end
      sidt_pkg::S_TAIL: begin
        ram_we_o = 1'b1;
      end
      sidt_pkg::S_INSERT: begin
        ram_we_o        = 1'b1;
        ram_waddr_o     = pos_q[IdxW-1:0];
        ram_wdata_o.cls = cls_q;
        ram_wdata_o.rid = rid_q;
        ram_wdata_o.lid = lid_q;
        cnt_d           = cnt_q + 1'b1;
      end
      sidt_pkg::S_SCAN: begin
        ram_raddr_o = pos_q[IdxW-1:0];
        if (scan_hit) begin
          res_d = rd.rid;
          st_d  = sidt_pkg::ST_OK;
        end else if (!scan_end) begin
          rv_d  = 1'b1;
          pos_d = pos_q + 1'b1;
        end
      end
      sidt_pkg::S_RESP: begin
        rsp_o.valid = rsp_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sidt_pkg::S_IDLE;
      cnt_q   <= '0;
      wpend_q <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wpend_q <= wpend_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    cls_q  <= cls_d;
    rid_q  <= rid_d;
    lid_q  <= lid_d;
    res_q  <= res_d;
    st_q   <= st_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    pos_q  <= pos_d;
    mid_q  <= mid_d;
    sh_q   <= sh_d;
    wa_q   <= wa_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity))
    else $error("fill count above capacity");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == sidt_pkg::S_SHIFT || state_q == sidt_pkg::S_TAIL ||
                  state_q == sidt_pkg::S_INSERT))
    else $error("table write outside insert sequence");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidt_pkg::S_INSERT) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not grow the table");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sidt_pkg::S_INSERT) |=> $stable(cnt_q))
    else $error("fill count changed outside insert");

  a_srch_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sidt_pkg::S_SCMP) |-> (lo_q < hi_q && hi_q <= cnt_q))
    else $error("search window out of range");
`endif

endmodule

// ===== dv/tb_sorted_id_translation_table.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_id_translation_table
// Self-checking bench for the sorted identifier translation table. A queue of
// requests is driven over the req channel with random gaps. A built-in
// predictor keeps its own sorted copy of the table and works out the
// expected response of every accepted request. The response channel is
// stalled at random, and every response is compared in order.
// ----------------------------------------------------------------------------
module tb_sorted_id_translation_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [sidt_pkg::ModeW-1:0] ModeUndef = 2'd3;
  localparam int unsigned RandItems   = 1330;
  localparam int unsigned MaxWait     = 18;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned MaxReported = 10;

  typedef logic [sidt_pkg::ClassW-1:0] cls_t;

  typedef struct {
    logic [sidt_pkg::ModeW-1:0]  mode;
    logic [sidt_pkg::ClassW-1:0] cls;
    logic [sidt_pkg::IdW-1:0]    rid;
    logic [sidt_pkg::IdW-1:0]    lid;
  } xlate_req_t;

  typedef struct {
    int unsigned              seq;
    logic [sidt_pkg::IdW-1:0] result_id;
    sidt_pkg::status_e        status;
  } xlate_rsp_t;

  logic clk_i;
  logic rst_ni;

  sidt_req_if req_bus ();
  sidt_rsp_if rsp_bus ();

  sorted_id_translation_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_bus),
    .rsp    (rsp_bus)
  );

  xlate_req_t        pending_req_q[$];
  xlate_rsp_t        expected_rsp_q[$];
  sidt_pkg::entry_t  known_key_q[$];

  sidt_pkg::entry_t  map_tbl[sidt_pkg::Capacity];
  int unsigned       map_fill;

  int unsigned req_issued;
  int unsigned req_taken;
  int unsigned req_gap;
  int unsigned req_calm;
  int unsigned rsp_taken;
  int unsigned rsp_seen;
  int unsigned rsp_stall;
  int unsigned rsp_calm;
  int unsigned fail_cnt;
  int unsigned stall_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // binary search over the sorted copy, insertion point on a miss
  function automatic bit locate_key(input logic [sidt_pkg::ClassW-1:0] cls,
                                    input logic [sidt_pkg::IdW-1:0] rid,
                                    output int unsigned pos);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = map_fill;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (cls < map_tbl[mid].cls ||
          (cls == map_tbl[mid].cls && rid < map_tbl[mid].rid)) begin
        hi = mid;
      end else if (cls > map_tbl[mid].cls || rid > map_tbl[mid].rid) begin
        lo = mid + 1;
      end else begin
        pos = mid;
        return 1'b1;
      end
    end
    pos = lo;
    return 1'b0;
  endfunction

  function automatic xlate_rsp_t translate(input logic [sidt_pkg::ModeW-1:0] mode,
                                           input logic [sidt_pkg::ClassW-1:0] cls,
                                           input logic [sidt_pkg::IdW-1:0] rid,
                                           input logic [sidt_pkg::IdW-1:0] lid);
    xlate_rsp_t  r;
    int unsigned pos;
    int unsigned i;
    r.seq       = req_taken;
    r.result_id = '0;
    r.status    = sidt_pkg::ST_MISS;
    case (mode)
      sidt_pkg::MODE_ADD: begin
        if (locate_key(cls, rid, pos)) begin
          r.status = (map_tbl[pos].lid == lid) ? sidt_pkg::ST_OK : sidt_pkg::ST_CONFLICT;
        end else if (map_fill >= sidt_pkg::Capacity) begin
          r.status = sidt_pkg::ST_FULL;
        end else begin
          for (i = map_fill; i > pos; i--) begin
            map_tbl[i] = map_tbl[i-1];
          end
          map_tbl[pos] = '{cls: cls, rid: rid, lid: lid};
          map_fill++;
          r.status = sidt_pkg::ST_OK;
        end
      end
      sidt_pkg::MODE_FWD: begin
        if (locate_key(cls, rid, pos)) begin
          r.result_id = map_tbl[pos].lid;
          r.status    = sidt_pkg::ST_OK;
        end else begin
          r.result_id = rid;
        end
      end
      sidt_pkg::MODE_REV: begin
        r.result_id = lid;
        void'(locate_key(cls, '0, pos));
        for (; pos < map_fill; pos++) begin
          if (map_tbl[pos].cls != cls) break;
          if (map_tbl[pos].lid == lid) begin
            r.result_id = map_tbl[pos].rid;
            r.status    = sidt_pkg::ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random wait per item, with runs of back-to-back items
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  function automatic logic [sidt_pkg::ClassW-1:0] rand_class();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd127;
      4: return 8'd128;
      5: return 8'd255;
      6: return 8'd254;
      default: return cls_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [sidt_pkg::IdW-1:0] rand_id();
    case ($urandom_range(0, 19))
      0, 1, 2: return $urandom_range(0, 15);
      3: return ~$urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [sidt_pkg::IdW-1:0] rand_local();
    if ($urandom_range(0, 9) < 3) return $urandom_range(0, 7);
    return rand_id();
  endfunction

  task automatic queue_req(input logic [sidt_pkg::ModeW-1:0] mode,
                           input logic [sidt_pkg::ClassW-1:0] cls,
                           input logic [sidt_pkg::IdW-1:0] rid,
                           input logic [sidt_pkg::IdW-1:0] lid);
    pending_req_q.push_back('{mode: mode, cls: cls, rid: rid, lid: lid});
    if (mode == sidt_pkg::MODE_ADD) begin
      known_key_q.push_back('{cls: cls, rid: rid, lid: lid});
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    xlate_req_t item;
    logic       drive_valid;
    if (rst_ni) begin
      drive_valid = req_bus.valid;
      if (req_bus.valid && req_taken == req_issued) begin
        drive_valid = 1'b0;
        req_gap     = draw_wait(req_calm);
      end
      if (!drive_valid && pending_req_q.size() != 0) begin
        if (req_gap == 0) begin
          item = pending_req_q.pop_front();
          req_bus.mode        <= item.mode;
          req_bus.entry_class <= item.cls;
          req_bus.remote_id   <= item.rid;
          req_bus.local_id    <= item.lid;
          drive_valid = 1'b1;
          req_issued++;
        end else begin
          req_gap--;
        end
      end
      req_bus.valid <= drive_valid;
    end
  end

  // response back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_taken != rsp_seen) begin
        rsp_seen  = rsp_taken;
        rsp_stall = draw_wait(rsp_calm);
      end
      if (rsp_stall != 0) begin
        rsp_stall--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    xlate_rsp_t exp_rsp;
    bit         fired;
    if (rst_ni) begin
      fired = 1'b0;
      if (req_bus.valid && req_bus.ready) begin
        expected_rsp_q.push_back(translate(req_bus.mode, req_bus.entry_class,
                                           req_bus.remote_id, req_bus.local_id));
        req_taken++;
        fired = 1'b1;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        rsp_taken++;
        fired = 1'b1;
        if (expected_rsp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReported) begin
            $display("%0t: response with no request open: id %h status %0d",
                     $realtime, rsp_bus.result_id, rsp_bus.status);
          end
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_bus.result_id !== exp_rsp.result_id || rsp_bus.status !== exp_rsp.status) begin
            fail_cnt++;
            if (fail_cnt <= MaxReported) begin
              $display("%0t: request %0d: expected id %h status %0d, got id %h status %0d",
                       $realtime, exp_rsp.seq, exp_rsp.result_id, exp_rsp.status,
                       rsp_bus.result_id, rsp_bus.status);
            end
          end
        end
      end
      if (fired || (pending_req_q.size() == 0 && expected_rsp_q.size() == 0 && !req_bus.valid))
      begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    if (stall_cycles == StallLimit) begin
      $display("tb_sorted_id_translation_table: FAIL");
      $finish;
    end
  end

  initial begin
    sidt_pkg::entry_t pick;
    int unsigned      queued;
    int unsigned      roll;
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.mode        = sidt_pkg::MODE_ADD;
    req_bus.entry_class = '0;
    req_bus.remote_id   = '0;
    req_bus.local_id    = '0;
    rsp_bus.ready       = 1'b0;
    map_fill     = 0;
    req_issued   = 0;
    req_taken    = 0;
    req_gap      = 0;
    req_calm     = 0;
    rsp_taken    = 0;
    rsp_seen     = 0;
    rsp_stall    = 0;
    rsp_calm     = 0;
    fail_cnt     = 0;
    stall_cycles = 0;

    // empty table
    queue_req(sidt_pkg::MODE_REV, 8'd5, 32'h0, 32'h7);
    queue_req(sidt_pkg::MODE_FWD, 8'd0, 32'h0, 32'h0);
    queue_req(ModeUndef, 8'd3, 32'h11, 32'h22);
    // extremes of the key
    queue_req(sidt_pkg::MODE_ADD, 8'd0, 32'h0, 32'h0);
    queue_req(sidt_pkg::MODE_ADD, 8'd255, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(sidt_pkg::MODE_ADD, 8'd0, 32'hffff_ffff, 32'h1234_5678);
    queue_req(sidt_pkg::MODE_ADD, 8'd255, 32'h0, 32'h0);
    queue_req(sidt_pkg::MODE_ADD, 8'd128, 32'h8000_0000, 32'ha5a5_a5a5);
    // existing key, same and different local id; forward lookups of present and absent keys
    queue_req(sidt_pkg::MODE_ADD, 8'd0, 32'h0, 32'h0);
    queue_req(sidt_pkg::MODE_ADD, 8'd0, 32'h0, 32'h1);
    queue_req(sidt_pkg::MODE_FWD, 8'd255, 32'hffff_ffff, 32'h0);
    queue_req(sidt_pkg::MODE_FWD, 8'd0, 32'hffff_ffff, 32'h0);
    queue_req(sidt_pkg::MODE_FWD, 8'd128, 32'h0, 32'h0);
    queue_req(sidt_pkg::MODE_FWD, 8'd127, 32'h5, 32'h0);
    // reverse lookups, first match wins within a class
    queue_req(sidt_pkg::MODE_ADD, 8'd0, 32'h5, 32'h0);
    queue_req(sidt_pkg::MODE_REV, 8'd0, 32'h0, 32'h0);
    queue_req(sidt_pkg::MODE_REV, 8'd255, 32'h0, 32'hffff_ffff);
    queue_req(sidt_pkg::MODE_REV, 8'd255, 32'hffff_ffff, 32'h0);
    queue_req(sidt_pkg::MODE_REV, 8'd0, 32'h0, 32'h99);
    queue_req(sidt_pkg::MODE_REV, 8'd7, 32'h0, 32'h0);
    queue_req(ModeUndef, 8'd255, 32'hffff_ffff, 32'hffff_ffff);

    queued = 0;
    while (queued < RandItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        roll = $urandom_range(0, 99);
        pick = known_key_q[$urandom_range(0, known_key_q.size() - 1)];
        if (roll < 60) begin
          queue_req(sidt_pkg::MODE_ADD, rand_class(), rand_id(), rand_local());
        end else if (roll < 85) begin
          queue_req(sidt_pkg::MODE_ADD, pick.cls, pick.rid, pick.lid);
        end else begin
          queue_req(sidt_pkg::MODE_ADD, pick.cls, pick.rid,
                    pick.lid + $urandom_range(1, 255));
        end
      end else if (roll < 75) begin
        pick = known_key_q[$urandom_range(0, known_key_q.size() - 1)];
        if ($urandom_range(0, 9) < 7) begin
          queue_req(sidt_pkg::MODE_FWD, pick.cls, pick.rid, $urandom());
        end else begin
          queue_req(sidt_pkg::MODE_FWD, rand_class(), rand_id(), $urandom());
        end
      end else if (roll < 99) begin
        pick = known_key_q[$urandom_range(0, known_key_q.size() - 1)];
        if ($urandom_range(0, 9) < 6) begin
          queue_req(sidt_pkg::MODE_REV, pick.cls, $urandom(), pick.lid);
        end else begin
          queue_req(sidt_pkg::MODE_REV, rand_class(), $urandom(), rand_local());
        end
      end else begin
        queue_req(ModeUndef, cls_t'($urandom_range(0, 255)), $urandom(), $urandom());
        queued--;
      end
      queued++;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_req_q.size() != 0 || req_bus.valid) @(negedge clk_i);
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("tb_sorted_id_translation_table: PASS");
    end else begin
      $display("tb_sorted_id_translation_table: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sidt_pkg.sv
rtl/sidt_if.sv
rtl/sidt_ram.sv
rtl/sidt_engine.sv
rtl/sorted_id_translation_table.sv
dv/tb_sorted_id_translation_table.sv
